### sv/iprt_pkg.sv
`timescale 1ns / 1ps

package iprt_pkg;

    localparam int MAX_ROUTES    = 16;
    localparam int IFACE_ID_BITS = 4;

    localparam logic [3:0] IFACE_KEEP = 4'((1 << IFACE_ID_BITS) - 1);

    localparam int FLAG_UP        = 0;
    localparam int FLAG_GATEWAY   = 1;
    localparam int FLAG_CONNECTED = 2;
    localparam int FLAG_LOCAL     = 3;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DEL    = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_REJECTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [31:0] local_address;
        logic [3:0]  iface_id;
        logic [7:0]  flags;
    } entry_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] route_dest;
        logic [31:0] route_mask;
        logic [31:0] route_gateway;
        logic [31:0] local_address;
        logic [3:0]  iface_id;
        logic [7:0]  route_flags;
        logic [31:0] lookup_address;
        logic [3:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_dest;
        logic [31:0] out_mask;
        logic [31:0] out_gateway;
        logic [31:0] out_local_address;
        logic [3:0]  out_iface_id;
        logic [7:0]  out_flags;
        logic [31:0] next_hop;
        logic [3:0]  hit_position;
        logic [4:0]  route_count;
    } rsp_t;

    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } done_t;

    // preference as a rank: local 3, connected 2, else 1, zero mask 0
    function automatic logic [1:0] pref_rank(input logic [7:0] flags, input logic [31:0] mask);
        logic [1:0] r;
        begin
            if (flags[FLAG_LOCAL])
                r = 2'd3;
            else if (flags[FLAG_CONNECTED])
                r = 2'd2;
            else if (mask == 32'd0)
                r = 2'd0;
            else
                r = 2'd1;
            return r;
        end
    endfunction

endpackage

### sv/iprt_req_if.sv
`timescale 1ns / 1ps

interface iprt_req_if;
    logic            valid;
    logic            ready;
    iprt_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/iprt_rsp_if.sv
`timescale 1ns / 1ps

interface iprt_rsp_if;
    logic            valid;
    logic            ready;
    iprt_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/iprt_ram.sv
`timescale 1ns / 1ps

module iprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### sv/iprt_seq.sv
`timescale 1ns / 1ps

module iprt_seq #(
    parameter int MAX_ROUTES = iprt_pkg::MAX_ROUTES,
    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1,
    localparam int CNT_W = $clog2(MAX_ROUTES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    iprt_req_if.sink              req,
    input  logic                  slot_free,
    output iprt_pkg::done_t       done,
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output iprt_pkg::entry_t      ram_wdata,
    output logic [IDX_W-1:0]      ram_raddr,
    input  iprt_pkg::entry_t      ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    iprt_pkg::req_t        req_reg, req_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    iprt_pkg::entry_t      best_reg, best_next;
    iprt_pkg::status_t     status_reg, status_next;

    iprt_pkg::entry_t      new_entry;
    iprt_pkg::entry_t      shown;
    logic                  issue;
    logic                  key_eq;
    logic                  cand;
    logic                  better;

    assign req.ready = state_reg[0];
    assign issue     = (ptr_reg < count_reg);

    always_comb
    begin
        new_entry.dest          = req_reg.route_dest;
        new_entry.mask          = req_reg.route_mask;
        new_entry.gateway       = req_reg.route_gateway;
        new_entry.local_address = req_reg.local_address;
        new_entry.iface_id      = req_reg.iface_id & iprt_pkg::IFACE_KEEP;
        new_entry.flags         = req_reg.route_flags | 8'(1 << iprt_pkg::FLAG_UP);
    end

    assign key_eq = (ram_rdata.dest == req_reg.route_dest)
                 && (ram_rdata.mask == req_reg.route_mask);
    assign cand   = ram_rdata.flags[iprt_pkg::FLAG_UP]
                 && ((req_reg.lookup_address & ram_rdata.mask)
                     == (ram_rdata.dest & ram_rdata.mask));
    assign better = !found_reg || (ram_rdata.mask > best_reg.mask)
                 || ((ram_rdata.mask == best_reg.mask)
                     && (iprt_pkg::pref_rank(ram_rdata.flags, ram_rdata.mask)
                         > iprt_pkg::pref_rank(best_reg.flags, best_reg.mask)));

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = pidx_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next      = req.data;
                    found_next    = 1'b0;
                    best_idx_next = '0;
                    pend_next     = 1'b0;
                    ptr_next      = '0;
                    status_next   = iprt_pkg::ST_NOTFOUND;
                    case (req.data.func)
                        iprt_pkg::FUNC_ADD:
                        begin
                            if (req.data.route_dest == 32'd0 && req.data.route_mask != 32'd0)
                            begin
                                status_next = iprt_pkg::ST_REJECTED;
                                state_next  = S_FIN;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        iprt_pkg::FUNC_READ:
                        begin
                            if (9'(req.data.entry_index) < 9'(count_reg))
                            begin
                                ram_raddr  = IDX_W'(req.data.entry_index);
                                pend_next  = 1'b1;
                                pidx_next  = IDX_W'(req.data.entry_index);
                                ptr_next   = count_reg;
                                state_next = S_SCAN;
                            end
                            else
                                state_next = S_FIN;
                        end
                        default:
                            state_next = S_SCAN;
                    endcase
                end
            end

            S_SCAN:
            begin
                // one read in flight; entry of the previous cycle is compared now
                if (issue)
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                end
                else
                    pend_next = 1'b0;

                if (pend_reg)
                begin
                    case (req_reg.func)
                        iprt_pkg::FUNC_ADD:
                        begin
                            if (key_eq && new_entry.iface_id != 4'd0
                                && ram_rdata.iface_id == new_entry.iface_id)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = pidx_reg;
                                ram_wdata     = new_entry;
                                found_next    = 1'b1;
                                best_idx_next = pidx_reg;
                                status_next   = iprt_pkg::ST_OK;
                                state_next    = S_FIN;
                            end
                        end
                        iprt_pkg::FUNC_DEL:
                        begin
                            if (key_eq)
                            begin
                                found_next    = 1'b1;
                                best_idx_next = pidx_reg;
                                status_next   = iprt_pkg::ST_OK;
                                ptr_next      = CNT_W'(pidx_reg) + 1'b1;
                                pend_next     = 1'b0;
                                state_next    = S_SHIFT;
                            end
                        end
                        iprt_pkg::FUNC_LOOKUP:
                        begin
                            if (cand && better)
                            begin
                                found_next    = 1'b1;
                                best_idx_next = pidx_reg;
                                best_next     = ram_rdata;
                                status_next   = iprt_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            found_next    = 1'b1;
                            best_idx_next = pidx_reg;
                            best_next     = ram_rdata;
                            status_next   = iprt_pkg::ST_OK;
                            state_next    = S_FIN;
                        end
                    endcase
                end
                else if (!issue)
                begin
                    if (req_reg.func == iprt_pkg::FUNC_ADD)
                    begin
                        if (count_reg >= CNT_W'(MAX_ROUTES))
                            status_next = iprt_pkg::ST_FULL;
                        else
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = count_reg[IDX_W-1:0];
                            ram_wdata     = new_entry;
                            count_next    = count_reg + 1'b1;
                            found_next    = 1'b1;
                            best_idx_next = count_reg[IDX_W-1:0];
                            status_next   = iprt_pkg::ST_OK;
                        end
                    end
                    state_next = S_FIN;
                end
            end

            S_SHIFT:
            begin
                // read entry j+1, write it to j in the following cycle
                if (issue)
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = IDX_W'(ptr_reg - 1'b1);
                end
                else
                    pend_next = 1'b0;

                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg;
                    ram_wdata = ram_rdata;
                end
                else if (!issue)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        shown = (req_reg.func == iprt_pkg::FUNC_ADD) ? new_entry : best_reg;
        done.valid = state_reg[3] && slot_free;
        done.rsp   = '0;
        done.rsp.status = status_reg;
        if (found_reg && req_reg.func != iprt_pkg::FUNC_DEL)
        begin
            done.rsp.out_dest          = shown.dest;
            done.rsp.out_mask          = shown.mask;
            done.rsp.out_gateway       = shown.gateway;
            done.rsp.out_local_address = shown.local_address;
            done.rsp.out_iface_id      = shown.iface_id;
            done.rsp.out_flags         = shown.flags;
        end
        if (found_reg && req_reg.func == iprt_pkg::FUNC_LOOKUP)
            done.rsp.next_hop = best_reg.flags[iprt_pkg::FLAG_GATEWAY]
                              ? best_reg.gateway : req_reg.lookup_address;
        if (found_reg)
            done.rsp.hit_position = 4'(best_idx_reg);
        done.rsp.route_count = 5'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ROUTES))
        else $error("route count above table size");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_SHIFT))
        else $error("table write outside scan or shift");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_SHIFT) |-> ((CNT_W'(pidx_reg) + 1'b1) < count_reg))
        else $error("shift write past last entry");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !slot_free) |=> state_reg == S_FIN)
        else $error("result dropped while output slot busy");

endmodule

### sv/ipv4_route_table_lookup_top.sv
`timescale 1ns / 1ps

// ipv4 route table: add/update, delete, longest-prefix lookup and read by index,
// one request at a time. the entries sit in one memory with a registered read
// and are scanned one per cycle. a lookup, an append or a miss scans the whole
// table; an update stops at its entry; a delete that hits stops at its entry
// and then shifts the rest down. read by index reads only its entry and a
// rejected add reads none. the result sits in an output register, so a new
// request is taken while the previous result waits.
module ipv4_route_table_lookup_top #(
    parameter int MAX_ROUTES = iprt_pkg::MAX_ROUTES
) (
    input logic        clk,
    input logic        rst_n,
    iprt_req_if.sink   req,
    iprt_rsp_if.source rsp
);

    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    iprt_pkg::entry_t  ram_wdata;
    iprt_pkg::entry_t  ram_rdata;
    iprt_pkg::done_t   done;
    logic              slot_free;
    logic              valid_reg;
    iprt_pkg::rsp_t    data_reg;

    iprt_ram #(
        .WIDTH ($bits(iprt_pkg::entry_t)),
        .DEPTH (MAX_ROUTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    iprt_seq #(
        .MAX_ROUTES (MAX_ROUTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .slot_free (slot_free),
        .done      (done),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // slot frees in the same cycle the held result transfers
    assign slot_free = !valid_reg || rsp.ready;
    assign rsp.valid = valid_reg;
    assign rsp.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (done.valid)
            valid_reg <= 1'b1;
        else if (rsp.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done.valid)
            data_reg <= done.rsp;
    end

endmodule

### test/tb_ipv4_route_table_lookup_top.sv
`timescale 1ns / 1ps

module tb_ipv4_route_table_lookup_top;

    // route table mirror with the expected-response queue
    class route_scoreboard;
        iprt_pkg::entry_t tbl[iprt_pkg::MAX_ROUTES];
        int               count;
        iprt_pkg::rsp_t   pending[$];
        int               errors;
        int               checked;

        function new();
            count   = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function int rank(logic [7:0] flags, logic [31:0] mask);
            if (flags[iprt_pkg::FLAG_LOCAL])
                return 300;
            if (flags[iprt_pkg::FLAG_CONNECTED])
                return 200;
            if (mask == 32'd0)
                return 0;
            return 100;
        endfunction

        function void fill(ref iprt_pkg::rsp_t r, input int i);
            r.out_dest          = tbl[i].dest;
            r.out_mask          = tbl[i].mask;
            r.out_gateway       = tbl[i].gateway;
            r.out_local_address = tbl[i].local_address;
            r.out_iface_id      = tbl[i].iface_id;
            r.out_flags         = tbl[i].flags;
            r.hit_position      = 4'(i);
        endfunction

        function void note_request(iprt_pkg::req_t q);
            iprt_pkg::rsp_t r;
            bit             done;
            int             best;
            int             best_pref;
            int             p;
            logic [7:0]     fl;
            logic [31:0]    best_mask;
            r        = '0;
            r.status = iprt_pkg::ST_NOTFOUND;
            done     = 0;
            best     = -1;
            best_pref = 0;
            best_mask = 0;
            case (iprt_pkg::func_t'(q.func))
                iprt_pkg::FUNC_ADD:
                begin
                    if (q.route_dest == 0 && q.route_mask != 0)
                        r.status = iprt_pkg::ST_REJECTED;
                    else
                    begin
                        fl = q.route_flags | 8'h01;
                        for (int i = 0; i < count && !done; i++)
                            if (tbl[i].dest == q.route_dest && tbl[i].mask == q.route_mask &&
                                q.iface_id != 0 && tbl[i].iface_id == q.iface_id)
                            begin
                                tbl[i].gateway       = q.route_gateway;
                                tbl[i].local_address = q.local_address;
                                tbl[i].flags         = fl;
                                r.status = iprt_pkg::ST_OK;
                                fill(r, i);
                                done = 1;
                            end
                        if (!done)
                        begin
                            if (count >= iprt_pkg::MAX_ROUTES)
                                r.status = iprt_pkg::ST_FULL;
                            else
                            begin
                                tbl[count] = '{q.route_dest, q.route_mask, q.route_gateway,
                                               q.local_address, q.iface_id, fl};
                                count++;
                                r.status = iprt_pkg::ST_OK;
                                fill(r, count - 1);
                            end
                        end
                    end
                end
                iprt_pkg::FUNC_DEL:
                begin
                    for (int i = 0; i < count && !done; i++)
                        if (tbl[i].dest == q.route_dest && tbl[i].mask == q.route_mask)
                        begin
                            for (int j = i; j + 1 < count; j++)
                                tbl[j] = tbl[j + 1];
                            count--;
                            r.status       = iprt_pkg::ST_OK;
                            r.hit_position = 4'(i);
                            done = 1;
                        end
                end
                iprt_pkg::FUNC_LOOKUP:
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        if (!tbl[i].flags[iprt_pkg::FLAG_UP])
                            continue;
                        if ((q.lookup_address & tbl[i].mask) != (tbl[i].dest & tbl[i].mask))
                            continue;
                        p = rank(tbl[i].flags, tbl[i].mask);
                        if (best < 0 || tbl[i].mask > best_mask ||
                            (tbl[i].mask == best_mask && p > best_pref))
                        begin
                            best      = i;
                            best_mask = tbl[i].mask;
                            best_pref = p;
                        end
                    end
                    if (best >= 0)
                    begin
                        r.status   = iprt_pkg::ST_OK;
                        fill(r, best);
                        r.next_hop = tbl[best].flags[iprt_pkg::FLAG_GATEWAY]
                                   ? tbl[best].gateway : q.lookup_address;
                    end
                end
                default:
                begin
                    if (q.entry_index < count)
                    begin
                        r.status = iprt_pkg::ST_OK;
                        fill(r, q.entry_index);
                    end
                end
            endcase
            r.route_count = 5'(count);
            pending.push_back(r);
        endfunction

        task check_response(iprt_pkg::rsp_t got);
            iprt_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                report("response with nothing expected", 0, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status != e.status) report("status", got.status, e.status);
            if (got.out_dest != e.out_dest) report("out_dest", got.out_dest, e.out_dest);
            if (got.out_mask != e.out_mask) report("out_mask", got.out_mask, e.out_mask);
            if (got.out_gateway != e.out_gateway)
                report("out_gateway", got.out_gateway, e.out_gateway);
            if (got.out_local_address != e.out_local_address)
                report("out_local_address", got.out_local_address, e.out_local_address);
            if (got.out_iface_id != e.out_iface_id)
                report("out_iface_id", got.out_iface_id, e.out_iface_id);
            if (got.out_flags != e.out_flags) report("out_flags", got.out_flags, e.out_flags);
            if (got.next_hop != e.next_hop) report("next_hop", got.next_hop, e.next_hop);
            if (got.hit_position != e.hit_position)
                report("hit_position", got.hit_position, e.hit_position);
            if (got.route_count != e.route_count)
                report("route_count", got.route_count, e.route_count);
        endtask

        task report(string what, logic [31:0] got, logic [31:0] exp);
            errors++;
            if (errors <= 30)
                $display("mismatch %0d: %s got %h expected %h", checked, what, got, exp);
        endtask
    endclass

    logic clk;
    logic rst_n;
    iprt_req_if req_ch ();
    iprt_rsp_if rsp_ch ();

    ipv4_route_table_lookup_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    route_scoreboard sb;
    int  cycles;
    int  sent;
    bit  no_idle;
    bit  hold_off;
    logic [31:0] dest_pool[8];
    logic [31:0] mask_pool[8];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout");
            $display("simulation failed");
            $finish;
        end
    end

    // accept on both sides, sampled at the edge
    always @(posedge clk)
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.data);
        end

    always @(posedge clk)
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= !hold_off && (no_idle || $urandom_range(99) >= 7);

    // long receiver stall so the block backs up into its input
    initial
    begin
        hold_off = 0;
        wait (sent >= 300);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    task automatic send(iprt_pkg::req_t q);
        while (!no_idle && $urandom_range(99) < 7)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic iprt_pkg::req_t make(iprt_pkg::func_t f, logic [31:0] d,
                                            logic [31:0] m, logic [31:0] g,
                                            logic [31:0] la, logic [3:0] id,
                                            logic [7:0] fl, logic [31:0] a,
                                            logic [3:0] ix);
        iprt_pkg::req_t q;
        q = '{f, d, m, g, la, id, fl, a, ix};
        return q;
    endfunction

    function automatic iprt_pkg::req_t random_req();
        iprt_pkg::req_t q;
        logic [223:0]   raw;
        int             k;
        int             pick;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        q = raw[$bits(iprt_pkg::req_t)-1:0];
        k = $urandom_range(7);
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            // well-formed: pooled prefixes so updates, deletes and lookups hit
            q.route_dest = dest_pool[k] & mask_pool[k];
            q.route_mask = mask_pool[k];
            q.iface_id   = 4'($urandom_range(3));
            if ($urandom_range(3) == 0)
                q.route_dest = dest_pool[k];
            q.lookup_address = dest_pool[$urandom_range(7)] ^ ($urandom & 32'h0000_0fff);
            q.entry_index = 4'($urandom_range(15));
            pick = $urandom_range(99);
            q.func = pick < 40 ? iprt_pkg::FUNC_ADD
                   : pick < 60 ? iprt_pkg::FUNC_DEL
                   : pick < 85 ? iprt_pkg::FUNC_LOOKUP
                   : iprt_pkg::FUNC_READ;
        end
        return q;
    endfunction

    initial
    begin
        int len;
        sent         = 0;
        no_idle      = 0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            len = $urandom_range(32);
            mask_pool[i] = len == 0 ? 32'd0 : ~(32'hffff_ffff >> len);
            dest_pool[i] = $urandom;
        end
        mask_pool[0] = 32'd0;
        mask_pool[1] = 32'hffff_ffff;
        // directed: empty table, rejects, flag kinds, ties, full table, deletes
        send(make(iprt_pkg::FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0));
        send(make(iprt_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 4'hf));
        send(make(iprt_pkg::FUNC_DEL, 32'h0a00_0000, 32'hff00_0000, 0, 0, 0, 0, 0, 0));
        send(make(iprt_pkg::FUNC_ADD, 0, 32'hffff_ffff, 1, 2, 1, 0, 0, 0));
        send(make(iprt_pkg::FUNC_ADD, 0, 0, 32'hc0a8_0001, 32'hc0a8_0002, 4'hf, 8'hf2,
                  0, 0));
        send(make(iprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_0001,
                  32'h0a00_00fe, 1, 8'h00, 0, 0));
        send(make(iprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 32'h1, 32'h2, 2, 8'h04,
                  0, 0));
        send(make(iprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 32'h3, 32'h4, 3, 8'h08,
                  0, 0));
        send(make(iprt_pkg::FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h0a01_0203, 0));
        send(make(iprt_pkg::FUNC_ADD, 32'h0a00_0000, 32'hff00_0000, 32'h5, 32'h6, 1, 8'h0a,
                  0, 0));
        send(make(iprt_pkg::FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h0a01_0203, 0));
        send(make(iprt_pkg::FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 4'hf, 8'hff, 0, 0));
        send(make(iprt_pkg::FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0));
        send(make(iprt_pkg::FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h5555_aaaa, 0));
        for (int i = 0; i < 12; i++)
            send(make(iprt_pkg::FUNC_ADD, 32'(i) << 8, 32'hffff_ff00, 0, 0, 0, 8'h00, 0, 0));
        send(make(iprt_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 4'hf));
        send(make(iprt_pkg::FUNC_DEL, 32'h0a00_0000, 32'hff00_0000, 0, 0, 0, 0, 0, 0));
        send(make(iprt_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 4'hf));
        send(make(iprt_pkg::FUNC_DEL, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
        // random phase, with a stretch of no idling in the middle
        for (int n = 0; n < 750; n++)
        begin
            no_idle = (n >= 500 && n < 600);
            send(random_req());
        end
        no_idle = 0;
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d requests and %0d responses across add, delete, lookup, read",
                 sent, sb.checked);
        $display("including rejects, full table, updates, preference ties and a long stall");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
sv/iprt_pkg.sv
sv/iprt_req_if.sv
sv/iprt_rsp_if.sv
sv/iprt_ram.sv
sv/iprt_seq.sv
sv/ipv4_route_table_lookup_top.sv
test/tb_ipv4_route_table_lookup_top.sv
